// File: hdl/tsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants of the text simhash fingerprint
// Word-event and result records, FNV-1a constants and field widths.
// ----------------------------------------------------------------------------
package tsf_pkg;

   localparam int HASH_W  = 64;
   localparam int COUNT_W = 16;
   localparam int BYTE_W  = 8;

   // 64-bit FNV-1a offset basis
   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;
   // FNV prime is 2^40 + 0x1B3: one shift plus a narrow constant product
   localparam int                FNV_PRIME_SHIFT = 40;
   localparam logic [8:0]        FNV_PRIME_LOW   = 9'h1B3;

   // Word close and/or end of text, handed from front to back
   typedef struct packed {
      logic              has_word;
      logic              last;
      logic [HASH_W-1:0] hash;
   } word_evt_type;

   // One finished fingerprint
   typedef struct packed {
      logic [HASH_W-1:0]  fingerprint;
      logic [COUNT_W-1:0] word_count;
      logic               vote_saturated;
   } result_type;

endpackage : tsf_pkg
`default_nettype wire

// File: hdl/text_simhash_fingerprint.sv
`default_nettype none
// Throughput: one byte per cycle; the FNV step (shift plus 9-bit constant product)
// closes in the front hasher each cycle, the back applies one word per cycle but
// waits at end of text on a full result queue. The front stalls only while the
// four-entry word queue is full. Results pass the word and result queues before a
// pop. Reset is synchronous and clears hash, counters, word count and both queues.
// ----------------------------------------------------------------------------
// text_simhash_fingerprint: 64-bit simhash over FNV-1a word hashes
// Front hashes words of the byte stream, back accumulates per-bit votes and
// delivers fingerprint, word count and saturation flag at end of text.
// ----------------------------------------------------------------------------
module text_simhash_fingerprint #(
   parameter int VOTE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic [tsf_pkg::BYTE_W-1:0]    req_text_byte,
   input  wire logic                          req_end_of_text,
   output logic                               empty,
   input  wire logic                          pop,
   output logic [tsf_pkg::HASH_W-1:0]         rsp_fingerprint,
   output logic [tsf_pkg::COUNT_W-1:0]        rsp_word_count,
   output logic                               rsp_vote_saturated
);
   import tsf_pkg::*;

   localparam int EVT_DEPTH = 4;
   localparam int RES_DEPTH = 2;

   logic         accept;
   logic         evt_push, evt_full, evt_empty, evt_pop;
   word_evt_type evt_wr, evt_rd;
   logic         res_push, res_full;
   result_type   res_wr, res_rd;

   assign accept = push && !full;
   assign full   = evt_full;

   // classify and hash
   tsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .evt_push    (evt_push),
      .evt         (evt_wr)
   );

   // decouple hasher from vote counters
   tsf_fifo #(
      .WIDTH ($bits(word_evt_type)),
      .DEPTH (EVT_DEPTH)
   ) u_evt_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (evt_push),
      .wr_data (evt_wr),
      .full    (evt_full),
      .pop     (evt_pop),
      .rd_data (evt_rd),
      .empty   (evt_empty)
   );

   // accumulate votes
   tsf_back #(
      .VOTE_BITS (VOTE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (!evt_empty),
      .evt       (evt_rd),
      .evt_pop   (evt_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res_wr)
   );

   // hold results until the consumer transfers them
   tsf_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RES_DEPTH)
   ) u_res_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_wr),
      .full    (res_full),
      .pop     (pop),
      .rd_data (res_rd),
      .empty   (empty)
   );

   assign rsp_fingerprint    = res_rd.fingerprint;
   assign rsp_word_count     = res_rd.word_count;
   assign rsp_vote_saturated = res_rd.vote_saturated;

   // no event is dropped at the word queue
   a_evt_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(evt_push && evt_full))
      else $error("word event pushed into full queue");

   // no result is dropped at the result queue
   a_res_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(res_push && res_full))
      else $error("result pushed into full queue");

   // a set fingerprint bit needs at least one counted word
   a_fp_needs_words : assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_fingerprint != '0)) |-> (rsp_word_count != '0))
      else $error("fingerprint set without words");

   // the back only pops an event that is present
   a_pop_when_valid : assert property (@(posedge clock) disable iff (reset)
      evt_pop |-> !evt_empty)
      else $error("word event popped from empty queue");

endmodule : text_simhash_fingerprint
`default_nettype wire

// File: hdl/tsf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_fifo: small register queue
// Holds DEPTH entries of WIDTH bits; the oldest entry is shown while not empty.
// ----------------------------------------------------------------------------
module tsf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   // advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write the entry on each transfer in
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule : tsf_fifo
`default_nettype wire

// File: hdl/tsf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_front: byte classifier and FNV-1a word hasher
// Lowers letters, hashes word bytes and emits one event per closed word or
// end of text.
// ----------------------------------------------------------------------------
module tsf_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [tsf_pkg::BYTE_W-1:0]   text_byte,
   input  wire logic                         end_of_text,
   output logic                              evt_push,
   output tsf_pkg::word_evt_type             evt
);
   import tsf_pkg::*;

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic              inside_ff, inside_in;
   logic              is_word, is_upper;
   logic [BYTE_W-1:0] lowered;
   logic [HASH_W-1:0] base, mixed, hashed;

   // classify: letters, digits and high bytes belong to words
   always_comb begin
      is_word  = text_byte inside {[8'h80:8'hFF], [8'h30:8'h39],
                                   [8'h41:8'h5A], [8'h61:8'h7A]};
      is_upper = text_byte inside {[8'h41:8'h5A]};
      lowered  = is_upper ? (text_byte | 8'h20) : text_byte;
   end

   // one FNV-1a step: xor the byte, multiply by the prime
   always_comb begin
      base   = inside_ff ? hash_ff : FNV_BASIS;
      mixed  = base ^ HASH_W'(lowered);
      hashed = (mixed << FNV_PRIME_SHIFT) + (mixed * HASH_W'(FNV_PRIME_LOW));
   end

   // track the open word and build the event
   always_comb begin
      hash_in      = hash_ff;
      inside_in    = inside_ff;
      evt.has_word = 1'b0;
      evt.last     = end_of_text;
      evt.hash     = hash_ff;
      evt_push     = 1'b0;
      if (accept) begin
         if (is_word) begin
            hash_in      = hashed;
            inside_in    = 1'b1;
            evt.has_word = end_of_text;
            evt.hash     = hashed;
         end else begin
            inside_in    = 1'b0;
            evt.has_word = inside_ff;
         end
         if (end_of_text) begin
            inside_in = 1'b0;
            hash_in   = '0;
         end
         evt_push = evt.has_word || end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff   <= '0;
         inside_ff <= 1'b0;
      end else begin
         hash_ff   <= hash_in;
         inside_ff <= inside_in;
      end
   end

endmodule : tsf_front
`default_nettype wire

// File: hdl/tsf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_back: vote counters and fingerprint builder
// Applies one word's votes per cycle to 64 saturating counters, but waits at end of
// text while the result queue is full, and emits the fingerprint at end of text.
// ----------------------------------------------------------------------------
module tsf_back #(
   parameter int VOTE_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  evt_valid,
   input  wire tsf_pkg::word_evt_type evt,
   output logic                       evt_pop,
   input  wire logic                  res_full,
   output logic                       res_push,
   output tsf_pkg::result_type        res
);
   import tsf_pkg::*;

   localparam logic [VOTE_BITS-1:0] VOTE_TOP = {1'b0, {(VOTE_BITS - 1){1'b1}}};
   localparam logic [VOTE_BITS-1:0] VOTE_BOT = {1'b1, {(VOTE_BITS - 1){1'b0}}};

   logic [VOTE_BITS-1:0] votes_ff [HASH_W];
   logic [VOTE_BITS-1:0] votes_in [HASH_W];
   logic [VOTE_BITS-1:0] votes_nx [HASH_W];
   logic [HASH_W-1:0]    vote_sat;
   logic [COUNT_W-1:0]   words_ff, words_in, words_nx;
   logic                 sat_ff, sat_in, sat_nx;
   logic                 words_sat;
   logic                 step;

   // hold an end-of-text event while the result queue is full
   assign step     = evt_valid && (!evt.last || !res_full);
   assign evt_pop  = step;
   assign res_push = step && evt.last;

   // vote per bit, holding at the limits
   always_comb begin
      for (int i = 0; i < HASH_W; i++) begin
         votes_nx[i] = votes_ff[i];
         vote_sat[i] = 1'b0;
         if (evt.has_word) begin
            if (evt.hash[i]) begin
               if (votes_ff[i] == VOTE_TOP) begin
                  vote_sat[i] = 1'b1;
               end else begin
                  votes_nx[i] = votes_ff[i] + VOTE_BITS'(1);
               end
            end else begin
               if (votes_ff[i] == VOTE_BOT) begin
                  vote_sat[i] = 1'b1;
               end else begin
                  votes_nx[i] = votes_ff[i] - VOTE_BITS'(1);
               end
            end
         end
      end
   end

   // count the word, holding at the limit
   always_comb begin
      words_nx  = words_ff;
      words_sat = 1'b0;
      if (evt.has_word) begin
         if (words_ff == {COUNT_W{1'b1}}) begin
            words_sat = 1'b1;
         end else begin
            words_nx = words_ff + COUNT_W'(1);
         end
      end
      sat_nx = sat_ff || words_sat || (|vote_sat);
   end

   // build the result from the updated counters
   always_comb begin
      for (int i = 0; i < HASH_W; i++) begin
         res.fingerprint[i] = !votes_nx[i][VOTE_BITS-1] && (votes_nx[i] != '0);
      end
      res.word_count     = words_nx;
      res.vote_saturated = sat_nx;
   end

   // advance on each step, clear after end of text
   always_comb begin
      for (int i = 0; i < HASH_W; i++) begin
         votes_in[i] = votes_ff[i];
         if (step) begin
            votes_in[i] = evt.last ? '0 : votes_nx[i];
         end
      end
      words_in = words_ff;
      sat_in   = sat_ff;
      if (step) begin
         words_in = evt.last ? '0 : words_nx;
         sat_in   = evt.last ? 1'b0 : sat_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HASH_W; i++) begin
            votes_ff[i] <= '0;
         end
         words_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         for (int i = 0; i < HASH_W; i++) begin
            votes_ff[i] <= votes_in[i];
         end
         words_ff <= words_in;
         sat_ff   <= sat_in;
      end
   end

endmodule : tsf_back
`default_nettype wire
